[rtl/mrrpm_pkg.sv]
package mrrpm_pkg;

   // Size tag store
   localparam int TAG_W = 17;
   localparam logic [TAG_W-1:0] WRAP_TAG = 17'h1FFFF;

   // Ring size limits and register reset values
   localparam int MIN_RING_BYTES = 64;
   localparam logic [16:0] QUEUE_BYTES_RESET = 17'd65536;
   localparam logic [7:0] CONFLATE_MASK_RESET = 8'd0;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [0:0] {
      CSR_QUEUE_BYTES   = 1'b0,
      CSR_CONFLATE_MASK = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      OP_SUBSCRIBE = 2'd0,
      OP_PUBLISH   = 2'd1,
      OP_RECEIVE   = 2'd2,
      OP_READY     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_EVICTED  = 3'd2,
      ST_BAD_SIZE = 3'd3,
      ST_CORRUPT  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  reader_slot;
      logic [31:0] owner_id;
      logic [15:0] msg_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot_granted;
      logic [15:0] payload_offset;
      logic [15:0] payload_bytes;
      logic [7:0]  overrun_readers;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       sub_exec;
      logic       pub_setup;
      logic       tag_wr_wrap;
      logic       scan_step;
      logic       pub_commit;
      logic       rd_setup;
      logic       rcv_wrap;
      logic       rcv_skip;
      logic       rcv_deliver;
      logic       rcv_empty;
      logic       set_status;
      status_type status_code;
      logic       out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type opcode;
      logic   pub_bad;
      logic   pub_wrap;
      logic   owner_bad;
      logic   scan_done;
      logic   hops_done;
      logic   at_wo;
      logic   idx_oob;
      logic   tag_wrap;
      logic   tag_bad;
      logic   conflate_skip;
   } dp_sts_type;

endpackage

[rtl/multi_reader_ring_pointer_manager.sv]
// Channel   Ports                      Direction  Moves
// req       req_valid/ready/payload    in         one request (opcode, slot, owner, length)
// rsp       rsp_valid/ready/payload    out        one result per request
// csr       csr_psel..csr_pready       in/out     queue_bytes at 0x0, conflate_mask at 0x4
//
// Accept to result: subscribe and rejected requests pass DECODE and FINISH; a ready
// query adds RDY_CHK; publish adds PUB_WRAP on wrap and one PUB_SCAN step per
// subscribed reader; receive adds RCV_LOOK, RCV_EVAL on delivery, and a LOOK/EVAL
// pair per followed wrap tag or skipped message, one tag store read per hop.
// Synchronous reset clears pointers, reader table and registers; the tag store
// is not cleared. A new request is taken while the last result waits on rsp_ready.
module multi_reader_ring_pointer_manager #(
   parameter int READER_SLOTS   = 8,
   parameter int MAX_RING_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mrrpm_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mrrpm_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mrrpm_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [mrrpm_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [mrrpm_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);

   logic [16:0]           queue_bytes_ff;
   logic [7:0]            conflate_mask_ff;
   logic                  csr_wr;
   mrrpm_pkg::csr_reg_type csr_sel;
   mrrpm_pkg::dp_cmd_type cmd;
   mrrpm_pkg::dp_sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel = mrrpm_pkg::csr_reg_type'(csr_paddr[2]);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         queue_bytes_ff <= mrrpm_pkg::QUEUE_BYTES_RESET;
         conflate_mask_ff <= mrrpm_pkg::CONFLATE_MASK_RESET;
      end else if (csr_wr) begin
         case (csr_sel)
            mrrpm_pkg::CSR_QUEUE_BYTES:   queue_bytes_ff <= csr_pwdata[16:0];
            mrrpm_pkg::CSR_CONFLATE_MASK: conflate_mask_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_sel)
         mrrpm_pkg::CSR_QUEUE_BYTES:   csr_prdata = {15'd0, queue_bytes_ff};
         mrrpm_pkg::CSR_CONFLATE_MASK: csr_prdata = {24'd0, conflate_mask_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   mrrpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mrrpm_dp #(
      .READER_SLOTS   (READER_SLOTS),
      .MAX_RING_BYTES (MAX_RING_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_payload   (req_payload),
      .queue_bytes   (queue_bytes_ff),
      .conflate_mask (conflate_mask_ff),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_payload   (rsp_payload)
   );

endmodule

[rtl/mrrpm_ram.sv]
module mrrpm_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8192
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mrrpm_ctrl.sv]
module mrrpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mrrpm_pkg::dp_cmd_type  cmd,
   input  mrrpm_pkg::dp_sts_type  sts
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECODE   = 8'b0000_0010,
      S_PUB_WRAP = 8'b0000_0100,
      S_PUB_SCAN = 8'b0000_1000,
      S_RDY_CHK  = 8'b0001_0000,
      S_RCV_LOOK = 8'b0010_0000,
      S_RCV_EVAL = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.opcode)
               mrrpm_pkg::OP_SUBSCRIBE: begin
                  cmd.sub_exec = 1'b1;
                  state_in = S_FINISH;
               end
               mrrpm_pkg::OP_PUBLISH: begin
                  if (sts.pub_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status_code = mrrpm_pkg::ST_BAD_SIZE;
                     state_in = S_FINISH;
                  end else begin
                     cmd.pub_setup = 1'b1;
                     state_in = sts.pub_wrap ? S_PUB_WRAP : S_PUB_SCAN;
                  end
               end
               default: begin
                  if (sts.owner_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status_code = mrrpm_pkg::ST_EVICTED;
                     state_in = S_FINISH;
                  end else begin
                     cmd.rd_setup = 1'b1;
                     state_in = (sts.opcode == mrrpm_pkg::OP_READY) ? S_RDY_CHK : S_RCV_LOOK;
                  end
               end
            endcase
         end
         S_PUB_WRAP: begin
            cmd.tag_wr_wrap = 1'b1;
            state_in = S_PUB_SCAN;
         end
         S_PUB_SCAN: begin
            if (sts.scan_done) begin
               cmd.pub_commit = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RDY_CHK: begin
            cmd.set_status = 1'b1;
            cmd.status_code = sts.at_wo ? mrrpm_pkg::ST_EMPTY : mrrpm_pkg::ST_OK;
            state_in = S_FINISH;
         end
         S_RCV_LOOK: begin
            if (sts.hops_done || (!sts.at_wo && sts.idx_oob)) begin
               cmd.set_status = 1'b1;
               cmd.status_code = mrrpm_pkg::ST_CORRUPT;
               state_in = S_FINISH;
            end else if (sts.at_wo) begin
               cmd.rcv_empty = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_code = mrrpm_pkg::ST_EMPTY;
               state_in = S_FINISH;
            end else begin
               state_in = S_RCV_EVAL;
            end
         end
         S_RCV_EVAL: begin
            if (sts.tag_wrap) begin
               cmd.rcv_wrap = 1'b1;
               state_in = S_RCV_LOOK;
            end else if (sts.tag_bad) begin
               cmd.set_status = 1'b1;
               cmd.status_code = mrrpm_pkg::ST_CORRUPT;
               state_in = S_FINISH;
            end else if (sts.conflate_skip) begin
               cmd.rcv_skip = 1'b1;
               state_in = S_RCV_LOOK;
            end else begin
               cmd.rcv_deliver = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_code = mrrpm_pkg::ST_OK;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Output register is only overwritten once its result has left
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   // One request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

   // Delivery only on a plain, in-range message tag
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      cmd.rcv_deliver |-> (!sts.tag_wrap && !sts.tag_bad && !sts.conflate_skip))
      else $error("message delivered from a bad or skipped tag");

   // State-changing commands never overlap
   a_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sub_exec, cmd.pub_commit, cmd.rcv_deliver, cmd.rcv_empty,
                cmd.scan_step, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

[rtl/mrrpm_dp.sv]
module mrrpm_dp #(
   parameter int READER_SLOTS   = 8,
   parameter int MAX_RING_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mrrpm_pkg::req_payload_type  req_payload,
   input  logic [16:0]                 queue_bytes,
   input  logic [7:0]                  conflate_mask,
   input  mrrpm_pkg::dp_cmd_type       cmd,
   output mrrpm_pkg::dp_sts_type       sts,
   output mrrpm_pkg::rsp_payload_type  rsp_payload
);

   localparam int SW          = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
   localparam int CW          = $clog2(READER_SLOTS + 1);
   localparam int TAG_ENTRIES = MAX_RING_BYTES / 8;
   localparam int TIW         = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
   localparam int TAG_SPAN    = TAG_ENTRIES * 8;
   localparam int RW          = $clog2(MAX_RING_BYTES) + 2;
   localparam int AW          = (RW > 19) ? RW + 1 : 20;
   localparam int QCW         = (RW > 17) ? RW : 17;
   localparam int NW          = QCW + 1;
   localparam int HOP_LIMIT   = MAX_RING_BYTES / 4 + 8;
   localparam int HW          = $clog2(HOP_LIMIT + 1);
   localparam int TW          = mrrpm_pkg::TAG_W;

   // Request and reader table
   mrrpm_pkg::req_payload_type req_ff;
   logic [RW-1:0]              write_offset_ff;
   logic [31:0]                write_laps_ff;
   logic [CW-1:0]              reader_count_ff;
   logic [RW-1:0]              reader_offset_ff [READER_SLOTS];
   logic [31:0]                reader_laps_ff   [READER_SLOTS];
   logic [31:0]                reader_owner_ff  [READER_SLOTS];
   logic [READER_SLOTS-1:0]    reader_valid_ff;

   // Publish scratch
   logic [RW-1:0] pub_wp_ff, pub_end_ff;
   logic [31:0]   pub_laps_ff;
   logic          pub_wrap_ff;
   logic [CW-1:0] scan_ff;

   // Receive scratch
   logic [RW-1:0] rp_ff;
   logic [31:0]   rl_ff;
   logic [HW-1:0] hops_ff;

   // Result
   mrrpm_pkg::status_type      res_status_ff;
   logic [2:0]                 res_granted_ff;
   logic [15:0]                res_poff_ff, res_pbytes_ff;
   logic [READER_SLOTS-1:0]    ovr_ff;
   logic [READER_SLOTS+7:0]    ovr_pad;
   mrrpm_pkg::rsp_payload_type rsp_ff;

   logic [QCW-1:0] qb_ext, q_clamp;
   logic [RW-1:0]  ring_q;
   logic [AW-1:0]  total, wp_sum;
   logic           pub_bad, pub_wrap;
   logic [RW-1:0]  wp_new, end_new;
   logic [31:0]    laps_new;
   logic [SW+2:0]  slot_pad;
   logic [SW-1:0]  req_idx, sel_idx, grant_idx;
   logic           slot_in_range, owner_bad, sub_full;
   logic [RW-1:0]  sel_off;
   logic [31:0]    sel_laps;
   logic           sel_valid, hit;
   logic [TW-1:0]  tag;
   logic [NW-1:0]  next_sum;
   logic [RW-1:0]  next_rp;
   logic           ram_we;
   logic [TIW-1:0] ram_waddr;
   logic [TW-1:0]  ram_wdata;

   // Effective ring size: clamp and round down to eight
   always_comb begin
      qb_ext = QCW'(queue_bytes);
      if (qb_ext < QCW'(mrrpm_pkg::MIN_RING_BYTES)) begin
         q_clamp = QCW'(mrrpm_pkg::MIN_RING_BYTES);
      end else if (qb_ext > QCW'(MAX_RING_BYTES)) begin
         q_clamp = QCW'(MAX_RING_BYTES);
      end else begin
         q_clamp = qb_ext;
      end
   end
   assign ring_q = RW'(q_clamp & ~QCW'(7));

   // Publish placement
   assign total    = (AW'(req_ff.msg_bytes) + AW'(15)) & ~AW'(7);
   assign pub_bad  = (req_ff.msg_bytes == 16'd0) || (((total << 1) + total) > AW'(ring_q));
   assign wp_sum   = AW'(write_offset_ff) + total + AW'(8);
   assign pub_wrap = (wp_sum >= AW'(ring_q));
   assign wp_new   = pub_wrap ? '0 : write_offset_ff;
   assign end_new  = RW'(AW'(wp_new) + total);
   assign laps_new = write_laps_ff + {31'd0, pub_wrap};

   // Slot selection
   assign slot_pad      = {SW'(0), req_ff.reader_slot};
   assign req_idx       = slot_pad[SW-1:0];
   assign slot_in_range = (slot_pad < (SW+3)'(READER_SLOTS));
   assign owner_bad     = !slot_in_range || (req_ff.owner_id == 32'd0) ||
                          (reader_owner_ff[req_idx] != req_ff.owner_id);
   assign sel_idx       = cmd.scan_step ? scan_ff[SW-1:0] : req_idx;
   assign sel_off       = reader_offset_ff[sel_idx];
   assign sel_laps      = reader_laps_ff[sel_idx];
   assign sel_valid     = reader_valid_ff[sel_idx];
   assign sub_full      = (reader_count_ff == CW'(READER_SLOTS));
   assign grant_idx     = sub_full ? '0 : reader_count_ff[SW-1:0];

   // Overrun test for one reader: wrapped past, or inside the new message
   assign hit = (pub_wrap_ff && (sel_off > write_offset_ff) && (sel_laps != write_laps_ff)) ||
                ((sel_off >= pub_wp_ff) && (sel_off < pub_end_ff) && (sel_laps != pub_laps_ff));

   // Receive hop
   assign next_sum = (NW'(rp_ff) + NW'(tag) + NW'(15)) & ~NW'(7);
   assign next_rp  = RW'(next_sum);

   // Tag store writes: wrap marker, then message length
   assign ram_we    = cmd.tag_wr_wrap || cmd.pub_commit;
   assign ram_waddr = cmd.tag_wr_wrap ? write_offset_ff[TIW+2:3] : pub_wp_ff[TIW+2:3];
   assign ram_wdata = cmd.tag_wr_wrap ? mrrpm_pkg::WRAP_TAG : TW'(req_ff.msg_bytes);

   mrrpm_ram #(
      .WIDTH (TW),
      .DEPTH (TAG_ENTRIES)
   ) u_tags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rp_ff[TIW+2:3]),
      .rd_data (tag)
   );

   // Status to controller
   always_comb begin
      sts.opcode        = mrrpm_pkg::op_type'(req_ff.opcode);
      sts.pub_bad       = pub_bad;
      sts.pub_wrap      = pub_wrap;
      sts.owner_bad     = owner_bad;
      sts.scan_done     = (scan_ff == reader_count_ff);
      sts.hops_done     = (hops_ff == HW'(HOP_LIMIT));
      sts.at_wo         = (rp_ff == write_offset_ff);
      sts.idx_oob       = (rp_ff >= RW'(TAG_SPAN));
      sts.tag_wrap      = (tag == mrrpm_pkg::WRAP_TAG);
      sts.tag_bad       = (tag == '0) || (QCW'(tag) >= QCW'(ring_q));
      sts.conflate_skip = conflate_mask[req_ff.reader_slot] && (next_rp != write_offset_ff);
   end

   // Pointer and reader table state
   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff <= '0;
         write_laps_ff <= '0;
         reader_count_ff <= '0;
         reader_valid_ff <= '0;
         for (int i = 0; i < READER_SLOTS; i++) begin
            reader_offset_ff[i] <= '0;
            reader_laps_ff[i] <= '0;
            reader_owner_ff[i] <= '0;
         end
      end else begin
         // Subscribe, evicting everyone when full
         if (cmd.sub_exec) begin
            for (int i = 0; i < READER_SLOTS; i++) begin
               if (SW'(i) == grant_idx) begin
                  reader_owner_ff[i] <= req_ff.owner_id;
                  reader_valid_ff[i] <= 1'b1;
               end else if (sub_full) begin
                  reader_owner_ff[i] <= '0;
                  reader_valid_ff[i] <= 1'b0;
               end
            end
            reader_offset_ff[grant_idx] <= write_offset_ff;
            reader_laps_ff[grant_idx] <= write_laps_ff;
            reader_count_ff <= sub_full ? CW'(1) : reader_count_ff + CW'(1);
         end
         // Resync an invalid reader to the writer
         if (cmd.rd_setup && !sel_valid) begin
            reader_valid_ff[req_idx] <= 1'b1;
            reader_offset_ff[req_idx] <= write_offset_ff;
            reader_laps_ff[req_idx] <= write_laps_ff;
         end
         if (cmd.scan_step && hit) begin
            reader_valid_ff[sel_idx] <= 1'b0;
         end
         if (cmd.pub_commit) begin
            write_offset_ff <= pub_end_ff;
            write_laps_ff <= pub_laps_ff;
         end
         if (cmd.rcv_empty || cmd.rcv_deliver) begin
            reader_offset_ff[req_idx] <= cmd.rcv_deliver ? next_rp : rp_ff;
            reader_laps_ff[req_idx] <= rl_ff;
         end
      end
   end

   // Request, scratch and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
         res_status_ff <= mrrpm_pkg::ST_OK;
         res_granted_ff <= '0;
         res_poff_ff <= '0;
         res_pbytes_ff <= '0;
         ovr_ff <= '0;
      end
      if (cmd.sub_exec) begin
         res_granted_ff <= 3'(grant_idx);
      end
      if (cmd.pub_setup) begin
         pub_wp_ff <= wp_new;
         pub_end_ff <= end_new;
         pub_laps_ff <= laps_new;
         pub_wrap_ff <= pub_wrap;
         scan_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (hit && sel_valid) begin
            ovr_ff[sel_idx] <= 1'b1;
         end
         scan_ff <= scan_ff + CW'(1);
      end
      if (cmd.pub_commit) begin
         res_poff_ff <= 16'(pub_wp_ff + RW'(8));
      end
      if (cmd.rd_setup) begin
         rp_ff <= sel_valid ? sel_off : write_offset_ff;
         rl_ff <= sel_valid ? sel_laps : write_laps_ff;
         hops_ff <= '0;
      end
      if (cmd.rcv_wrap) begin
         rp_ff <= '0;
         rl_ff <= rl_ff + 32'd1;
         hops_ff <= hops_ff + HW'(1);
      end
      if (cmd.rcv_skip) begin
         rp_ff <= next_rp;
         hops_ff <= hops_ff + HW'(1);
      end
      if (cmd.rcv_deliver) begin
         res_poff_ff <= 16'(rp_ff + RW'(8));
         res_pbytes_ff <= tag[15:0];
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
      if (cmd.out_load) begin
         rsp_ff.status <= res_status_ff;
         rsp_ff.slot_granted <= res_granted_ff;
         rsp_ff.payload_offset <= res_poff_ff;
         rsp_ff.payload_bytes <= res_pbytes_ff;
         rsp_ff.overrun_readers <= ovr_pad[7:0];
      end
   end

   assign ovr_pad = {8'd0, ovr_ff};
   assign rsp_payload = rsp_ff;

endmodule
